[rtl/nsvc_pkg.sv]
// Shared types and constants for the nearest-seed Voronoi colorer.
// No dependencies; imported by nsvc_dist, nsvc_seq and the top level under rtl/.
package nsvc_pkg;

    localparam int SLOT_W          = 6;   // seed_slot and winner field width
    localparam int CHAN_W          = 8;   // one color channel
    localparam int COLOR_W         = 3 * CHAN_W;
    localparam int COUNT_W         = 7;   // seed_count register width
    localparam int MAX_SEEDS_DEF   = 64;
    localparam int COORD_BITS_DEF  = 12;
    localparam int M_TDATA_W       = 32;  // red, green, blue, winner, zero fill

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_PUT
    } seq_state_t;

    // Flags that travel with one seed through the distance pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } issue_t;

endpackage

[rtl/nsvc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module nsvc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/nsvc_dist.sv]
// Shared squared-distance and compare unit: abs diff, square, add and keep the minimum.
// Depends on nsvc_pkg (issue_t, COLOR_W).
module nsvc_dist #(
    parameter int COORD_BITS = nsvc_pkg::COORD_BITS_DEF,
    parameter int ADDR_W     = 6
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  nsvc_pkg::issue_t                     issue,
    input  logic [ADDR_W-1:0]                    issue_idx,
    input  logic [COORD_BITS-1:0]                px,
    input  logic [COORD_BITS-1:0]                py,
    input  logic [2*COORD_BITS+nsvc_pkg::COLOR_W-1:0] seed_word,
    output logic [ADDR_W-1:0]                    best_idx,
    output logic [nsvc_pkg::COLOR_W-1:0]         best_color,
    output logic                                 done
);
    import nsvc_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int SQ_W = 2 * CB;

    logic [CB-1:0]      col, row;
    logic [COLOR_W-1:0] color;

    // stage 1: absolute differences
    issue_t             s1_reg;
    logic [ADDR_W-1:0]  idx1_reg;
    logic [COLOR_W-1:0] color1_reg;
    logic [CB-1:0]      adx_reg, ady_reg, adx_next, ady_next;

    // stage 2: squares
    issue_t             s2_reg;
    logic [ADDR_W-1:0]  idx2_reg;
    logic [COLOR_W-1:0] color2_reg;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg, sqx_next, sqy_next;

    // stage 3: sum and running minimum
    logic [SQ_W:0]      sum;
    logic               take;
    logic [SQ_W:0]      best_d_reg;
    logic [ADDR_W-1:0]  best_idx_reg;
    logic [COLOR_W-1:0] best_color_reg;
    logic               done_reg;

    assign col   = seed_word[CB-1:0];
    assign row   = seed_word[2*CB-1:CB];
    assign color = seed_word[2*CB +: COLOR_W];

    always_comb begin
        adx_next = (px >= col) ? (px - col) : (col - px);
        ady_next = (py >= row) ? (py - row) : (row - py);
        sqx_next = {{CB{1'b0}}, adx_reg} * {{CB{1'b0}}, adx_reg};
        sqy_next = {{CB{1'b0}}, ady_reg} * {{CB{1'b0}}, ady_reg};
        sum      = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        // strict less-than keeps the lowest index on ties
        take     = s2_reg.valid && (s2_reg.first || (sum < best_d_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg   <= '0;
            s2_reg   <= '0;
            done_reg <= 1'b0;
        end else begin
            s1_reg   <= issue;
            s2_reg   <= s1_reg;
            done_reg <= s2_reg.valid && s2_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg   <= issue_idx;
        color1_reg <= color;
        adx_reg    <= adx_next;
        ady_reg    <= ady_next;
        idx2_reg   <= idx1_reg;
        color2_reg <= color1_reg;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        if (take) begin
            best_d_reg     <= sum;
            best_idx_reg   <= idx2_reg;
            best_color_reg <= color2_reg;
        end
    end

    assign best_idx   = best_idx_reg;
    assign best_color = best_color_reg;
    assign done       = done_reg;

    // only one search can be draining at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({s1_reg.valid && s1_reg.last, s2_reg.valid && s2_reg.last}) <= 1)
        else $error("two search ends in flight in distance pipeline");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_reg.valid && s1_reg.first |-> idx1_reg == '0)
        else $error("search does not start at slot zero");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s2_reg.valid && s2_reg.last |=> done_reg)
        else $error("last seed compared without done");

endmodule

[rtl/nsvc_seq.sv]
// Sequencer: walks the seed store once per pixel and hands the result to the output.
// Depends on nsvc_pkg (seq_state_t, issue_t, COUNT_W).
module nsvc_seq #(
    parameter int MAX_SEEDS = nsvc_pkg::MAX_SEEDS_DEF,
    parameter int ADDR_W    = 6
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         pix_start,
    input  logic [nsvc_pkg::COUNT_W-1:0] seed_count,
    input  logic                         dist_done,
    input  logic                         out_free,
    output logic                         in_ready,
    output logic                         rd_en,
    output logic [ADDR_W-1:0]            rd_addr,
    output nsvc_pkg::issue_t             issue,
    output logic [ADDR_W-1:0]            issue_idx,
    output logic                         out_load
);
    import nsvc_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] last_reg, last_next;
    issue_t            issue_reg, issue_next;
    logic [ADDR_W-1:0] idx_reg;
    logic [31:0]       cnt_c;

    // effective count: zero searches slot zero, large values saturate
    always_comb begin
        cnt_c = 32'(seed_count);
        if (cnt_c == 32'd0) begin
            cnt_c = 32'd1;
        end
        if (cnt_c > 32'(MAX_SEEDS)) begin
            cnt_c = 32'(MAX_SEEDS);
        end
    end

    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        last_next  = last_reg;
        issue_next = '0;
        in_ready   = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (pix_start) begin
                    addr_next  = '0;
                    last_next  = ADDR_W'(cnt_c - 32'd1);
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                rd_en            = 1'b1;
                issue_next.valid = 1'b1;
                issue_next.first = (addr_reg == '0);
                issue_next.last  = (addr_reg == last_reg);
                if (addr_reg == last_reg) begin
                    state_next = ST_WAIT;
                end else begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            ST_WAIT: begin
                if (dist_done) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_PUT;
                    end
                end
            end
            ST_PUT: begin
                // hold the result until the output register drains
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            issue_reg <= '0;
        end else begin
            state_reg <= state_next;
            issue_reg <= issue_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        last_reg <= last_next;
        idx_reg  <= addr_reg;
    end

    assign rd_addr   = addr_reg;
    assign issue     = issue_reg;
    assign issue_idx = idx_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ISSUE |-> addr_reg <= last_reg)
        else $error("seed address ran past the last seed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        dist_done |-> state_reg == ST_WAIT)
        else $error("search finished outside the wait state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> state_reg == ST_IDLE)
        else $error("sequencer not idle after handing off a result");

endmodule

[rtl/nearest_seed_voronoi_color.sv]
// Top level of the nearest-seed Voronoi colorer: ports, seed store, output register.
// Depends on nsvc_pkg, nsvc_ram, nsvc_seq and nsvc_dist.
//
//  channel | direction | fields
//  --------+-----------+------------------------------------------------------------
//  s_axis  | in        | tuser: kind; tdata: seed_slot, pos_x, pos_y, red, green, blue
//  m_axis  | out       | tdata: red_out, green_out, blue_out, winner
//  cfg     | in        | cfg_wdata: seed_count, written when cfg_we is high
//
// A load transfer writes the seed store in its accept cycle; the block is ready again
// in the next cycle. A pixel transfer is searched by the single distance/compare unit,
// which takes one seed per cycle from the store's registered read port and passes it
// through the absolute-difference, square and sum/minimum stages to the output.
// The next transfer is accepted while a result waits on m_axis; a finished search
// holds until the output register is free. Reset sets seed_count to 1.
module nearest_seed_voronoi_color #(
    parameter int MAX_SEEDS  = nsvc_pkg::MAX_SEEDS_DEF,
    parameter int COORD_BITS = nsvc_pkg::COORD_BITS_DEF,
    localparam int S_TDATA_W =
        ((nsvc_pkg::SLOT_W + 2 * COORD_BITS + nsvc_pkg::COLOR_W + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // seed_slot, pos_x, pos_y, red_in, green_in, blue_in, zero fill
    input  logic [S_TDATA_W-1:0]           s_axis_tdata,
    // kind
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // red_out, green_out, blue_out, winner, zero fill
    output logic [nsvc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                           cfg_we,
    input  logic [nsvc_pkg::COUNT_W-1:0]   cfg_wdata
);
    import nsvc_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int ADDR_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
    localparam int WORD_W = 2 * CB + COLOR_W;

    logic [SLOT_W-1:0]  seed_slot;
    logic [CB-1:0]      pos_x, pos_y;
    logic [COLOR_W-1:0] color_in;

    logic               in_ready, accept, load_we, pix_start;
    logic [COUNT_W-1:0] seed_count_reg;
    logic [CB-1:0]      px_reg, py_reg;

    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [WORD_W-1:0]  seed_word;
    issue_t             issue;
    logic [ADDR_W-1:0]  issue_idx;
    logic [ADDR_W-1:0]  best_idx;
    logic [COLOR_W-1:0] best_color;
    logic               dist_done, out_load, out_free;

    logic               m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    assign seed_slot = s_axis_tdata[SLOT_W-1:0];
    assign pos_x     = s_axis_tdata[SLOT_W +: CB];
    assign pos_y     = s_axis_tdata[SLOT_W + CB +: CB];
    // red, green, blue in rising bit order on the bus; store red in the top byte
    assign color_in  = {s_axis_tdata[SLOT_W + 2*CB +: CHAN_W],
                        s_axis_tdata[SLOT_W + 2*CB + CHAN_W +: CHAN_W],
                        s_axis_tdata[SLOT_W + 2*CB + 2*CHAN_W +: CHAN_W]};

    assign s_axis_tready = in_ready;
    assign accept        = s_axis_tvalid && in_ready;
    // drop loads aimed past the end of the store
    assign load_we       = accept && (s_axis_tuser == KIND_LOAD)
                           && (32'(seed_slot) < 32'(MAX_SEEDS));
    assign pix_start     = accept && (s_axis_tuser == KIND_PIXEL);
    assign out_free      = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_count_reg <= COUNT_W'(1);
        end else if (cfg_we) begin
            seed_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_start) begin
            px_reg <= pos_x;
            py_reg <= pos_y;
        end
    end

    nsvc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_SEEDS),
        .AW    (ADDR_W)
    ) u_seed_ram (
        .aclk  (aclk),
        .we    (load_we),
        .waddr (ADDR_W'(seed_slot)),
        .wdata ({color_in, pos_y, pos_x}),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (seed_word)
    );

    nsvc_seq #(
        .MAX_SEEDS (MAX_SEEDS),
        .ADDR_W    (ADDR_W)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pix_start  (pix_start),
        .seed_count (seed_count_reg),
        .dist_done  (dist_done),
        .out_free   (out_free),
        .in_ready   (in_ready),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .issue      (issue),
        .issue_idx  (issue_idx),
        .out_load   (out_load)
    );

    nsvc_dist #(
        .COORD_BITS (COORD_BITS),
        .ADDR_W     (ADDR_W)
    ) u_dist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .issue      (issue),
        .issue_idx  (issue_idx),
        .px         (px_reg),
        .py         (py_reg),
        .seed_word  (seed_word),
        .best_idx   (best_idx),
        .best_color (best_color),
        .done       (dist_done)
    );

    always_comb begin
        m_data_next = {{(M_TDATA_W - COLOR_W - SLOT_W){1'b0}},
                       SLOT_W'(best_idx),
                       best_color[CHAN_W-1:0],
                       best_color[CHAN_W +: CHAN_W],
                       best_color[2*CHAN_W +: CHAN_W]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_axis_tvalid && m_axis_tdata == $past(m_data_next))
        else $error("result not presented after hand-off");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pix_start |=> !s_axis_tready)
        else $error("input accepted during a pixel search");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !s_axis_tready)
        else $error("result handed off while idle");

endmodule

[tb/sv/nearest_seed_voronoi_color_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for nearest_seed_voronoi_color: watches the input, result and config ports,
// keeps its own copy of the seed store and seed count, predicts each pixel and compares.
// Depends on nsvc_pkg for field widths and the transfer kind codes.
module nearest_seed_voronoi_color_checker #(
    parameter int S_TDATA_W  = 56,
    parameter int COORD_BITS = 12,
    parameter int SEED_SLOTS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [S_TDATA_W-1:0]           s_axis_tdata,
    input  logic                           s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [nsvc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                           cfg_we,
    input  logic [nsvc_pkg::COUNT_W-1:0]   cfg_wdata,
    output int                             mismatch_count,
    output int                             colors_owed
);
    import nsvc_pkg::*;

    localparam int X_LSB   = SLOT_W;
    localparam int Y_LSB   = X_LSB + COORD_BITS;
    localparam int RGB_LSB = Y_LSB + COORD_BITS;

    typedef logic [COORD_BITS-1:0] coord_t;

    // Same layout as the low bits of m_axis_tdata: red lowest, winner on top
    typedef struct packed {
        logic [SLOT_W-1:0] winner;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } paint_t;

    coord_t               seed_x   [SEED_SLOTS];
    coord_t               seed_y   [SEED_SLOTS];
    logic [COLOR_W-1:0]   seed_rgb [SEED_SLOTS];   // blue, green, red from the top down
    logic [COUNT_W-1:0]   seeds_in_use;
    paint_t               owed_q[$];
    paint_t               got;
    paint_t               want;
    logic [SLOT_W-1:0]    load_slot;

    task automatic flag_mismatch(input string what, input int unsigned seen,
                                 input int unsigned owed);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, seen, owed);
        mismatch_count++;
    endtask

    function automatic longint unsigned dist_sq(input coord_t px, input coord_t py,
                                                input int slot);
        longint unsigned dx;
        longint unsigned dy;
        dx = (px >= seed_x[slot]) ? px - seed_x[slot] : seed_x[slot] - px;
        dy = (py >= seed_y[slot]) ? py - seed_y[slot] : seed_y[slot] - py;
        return dx * dx + dy * dy;
    endfunction

    function automatic paint_t nearest_seed(input coord_t px, input coord_t py);
        int unsigned     span;
        int unsigned     best;
        longint unsigned best_d;
        longint unsigned d;
        paint_t          p;
        // zero still searches slot 0, anything past the store saturates
        span = (seeds_in_use == 0) ? 1 :
               ((seeds_in_use > SEED_SLOTS) ? SEED_SLOTS : seeds_in_use);
        best = 0;
        best_d = dist_sq(px, py, 0);
        for (int i = 1; i < span; i++) begin
            d = dist_sq(px, py, i);
            // strict compare keeps the lowest index on ties
            if (d < best_d) begin
                best_d = d;
                best = i;
            end
        end
        p = {best[SLOT_W-1:0], seed_rgb[best]};
        return p;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            seeds_in_use = 1;
            owed_q.delete();
        end else begin
            if (cfg_we)
                seeds_in_use = cfg_wdata;

            // retire before predicting: a result never belongs to a pixel taken this edge
            if (m_axis_tvalid && m_axis_tready) begin
                got = paint_t'(m_axis_tdata[SLOT_W+COLOR_W-1:0]);
                if (owed_q.size() == 0) begin
                    flag_mismatch("result with no pixel pending", got, 0);
                end else begin
                    want = owed_q.pop_front();
                    if (got.red !== want.red)
                        flag_mismatch("red_out", got.red, want.red);
                    if (got.green !== want.green)
                        flag_mismatch("green_out", got.green, want.green);
                    if (got.blue !== want.blue)
                        flag_mismatch("blue_out", got.blue, want.blue);
                    if (got.winner !== want.winner)
                        flag_mismatch("winner", got.winner, want.winner);
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == KIND_LOAD) begin
                    load_slot = s_axis_tdata[SLOT_W-1:0];
                    if (load_slot < SEED_SLOTS) begin
                        seed_x[load_slot]   = s_axis_tdata[X_LSB +: COORD_BITS];
                        seed_y[load_slot]   = s_axis_tdata[Y_LSB +: COORD_BITS];
                        seed_rgb[load_slot] = s_axis_tdata[RGB_LSB +: COLOR_W];
                    end
                end else begin
                    // append at the tail so results retire in transfer order
                    owed_q.insert(owed_q.size(),
                                  nearest_seed(s_axis_tdata[X_LSB +: COORD_BITS],
                                               s_axis_tdata[Y_LSB +: COORD_BITS]));
                end
            end
        end
        colors_owed <= owed_q.size();
    end

endmodule

[tb/sv/nearest_seed_voronoi_color_tb.sv]
`timescale 1ns / 100ps
// Top of the nearest_seed_voronoi_color testbench: clock, reset, seed/pixel stimulus,
// result-side back-pressure and the verdict. Depends on nsvc_pkg and the checker module.
module nearest_seed_voronoi_color_tb;
    import nsvc_pkg::*;

    localparam int COORD_W      = COORD_BITS_DEF;
    localparam int SEEDS        = MAX_SEEDS_DEF;
    localparam int S_TDATA_W    = ((SLOT_W + 2 * COORD_W + COLOR_W + 7) / 8) * 8;
    localparam int FILL_W       = S_TDATA_W - SLOT_W - 2 * COORD_W - COLOR_W;
    localparam int DRAIN_CYCLES = SEEDS + 16;
    localparam int LONG_HOLD    = 400;
    localparam int QUIET_LIMIT  = 5000;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 84;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;   // seed_slot, pos_x, pos_y, red, green, blue
    logic                   s_axis_tuser  = KIND_LOAD;   // kind
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;         // red_out, green_out, blue_out, winner
    logic                   cfg_we        = 1'b0;
    logic [COUNT_W-1:0]     cfg_wdata     = '0;

    int                     mismatch_count;
    int                     colors_owed;

    // stimulus-side view of the seed store, so pixels only search loaded slots
    bit                     seed_loaded [SEEDS];
    logic [COORD_W-1:0]     seed_px     [SEEDS];
    logic [COORD_W-1:0]     seed_py     [SEEDS];
    int unsigned            seeds_live     = 1;
    int unsigned            send_idle_pct  = 0;
    int unsigned            recv_stall_pct = 0;
    int                     hold_requests  = 0;
    int                     holds_done     = 0;
    int                     hold_left      = 0;
    int                     quiet_cycles   = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    nearest_seed_voronoi_color #(
        .MAX_SEEDS  (SEEDS),
        .COORD_BITS (COORD_W)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    nearest_seed_voronoi_color_checker #(
        .S_TDATA_W  (S_TDATA_W),
        .COORD_BITS (COORD_W),
        .SEED_SLOTS (SEEDS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .colors_owed    (colors_owed)
    );

    // Result side: random stalls, plus a long hold-off whenever one is requested
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != hold_requests) begin
            m_axis_tready <= 1'b0;
            holds_done <= holds_done + 1;
            hold_left <= LONG_HOLD;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // End the run if nothing moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Called and returns at a falling edge; holds tvalid high into the next transfer
    task automatic send_item(input logic kind, input int slot, input int x, input int y,
                             input int r, input int g, input int b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{FILL_W{1'b0}}, b[CHAN_W-1:0], g[CHAN_W-1:0], r[CHAN_W-1:0],
                          y[COORD_W-1:0], x[COORD_W-1:0], slot[SLOT_W-1:0]};
        if (kind == KIND_LOAD) begin
            seed_loaded[slot] = 1'b1;
            seed_px[slot] = x[COORD_W-1:0];
            seed_py[slot] = y[COORD_W-1:0];
        end
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop offering, wait for every owed result, then let a late search run out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (colors_owed != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_seed_count(input int unsigned count);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= count[COUNT_W-1:0];
        @(negedge aclk);
        cfg_we    <= 1'b0;
        seeds_live = (count == 0) ? 1 : ((count > SEEDS) ? SEEDS : count);
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic random_item();
        int gap_slot;
        int pick;
        int x;
        int y;
        gap_slot = -1;
        for (int i = 0; i < seeds_live; i++)
            if (!seed_loaded[i] && gap_slot < 0)
                gap_slot = i;
        x = $urandom_range(2 ** COORD_W - 1);
        y = $urandom_range(2 ** COORD_W - 1);

        if (gap_slot >= 0) begin
            // fill the searched range first so no search reads an empty slot
            send_item(KIND_LOAD, gap_slot, x, y, $urandom_range(255), $urandom_range(255),
                      $urandom_range(255));
        end else if ($urandom_range(99) < 30) begin
            if ($urandom_range(9) == 0) begin
                // stack a seed on top of another to force exact ties
                pick = $urandom_range(SEEDS - 1);
                x = seed_px[pick];
                y = seed_py[pick];
            end
            send_item(KIND_LOAD, $urandom_range(SEEDS - 1), x, y, $urandom_range(255),
                      $urandom_range(255), $urandom_range(255));
        end else begin
            if ($urandom_range(3) == 0) begin
                // land close to a live seed; wraps past the edges like the coordinates do
                pick = $urandom_range(seeds_live - 1);
                x = seed_px[pick] + $urandom_range(6) - 3;
                y = seed_py[pick] + $urandom_range(6) - 3;
            end
            send_item(KIND_PIXEL, $urandom_range(SEEDS - 1), x, y, $urandom_range(255),
                      $urandom_range(255), $urandom_range(255));
        end
    endtask

    initial begin
        int unsigned count;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset count of one: a single seed at both corners, black then white
        send_item(KIND_LOAD, 0, 0, 0, 0, 0, 0);
        send_item(KIND_PIXEL, SEEDS - 1, 0, 0, 255, 255, 255);
        send_item(KIND_PIXEL, 0, 4095, 4095, 0, 0, 0);
        send_item(KIND_LOAD, 0, 4095, 4095, 255, 255, 255);
        send_item(KIND_PIXEL, 0, 0, 0, 0, 0, 0);

        // Count zero still searches slot zero
        set_seed_count(0);
        send_item(KIND_PIXEL, 21, 123, 4000, 0, 0, 0);

        // Ties between neighbors go to the lower slot
        set_seed_count(3);
        send_item(KIND_LOAD, 1, 2000, 1000, 1, 2, 3);
        send_item(KIND_LOAD, 2, 2002, 1000, 170, 85, 204);
        send_item(KIND_LOAD, 0, 2004, 1000, 255, 0, 128);
        send_item(KIND_PIXEL, 5, 2001, 1000, 0, 0, 0);
        send_item(KIND_PIXEL, 42, 2003, 1000, 0, 0, 0);
        send_item(KIND_PIXEL, 0, 2002, 1000, 0, 0, 0);
        send_item(KIND_LOAD, SEEDS - 1, 4095, 0, 0, 255, 0);
        send_item(KIND_PIXEL, 63, 4095, 0, 0, 0, 0);
        send_item(KIND_LOAD, 1, 2004, 1000, 9, 9, 9);
        send_item(KIND_PIXEL, 7, 2004, 1000, 0, 0, 0);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(81, 0);
                2: set_idling(0, 81);
                default: set_idling(38, 38);
            endcase
            case (phase)
                0: count = SEEDS;
                1: count = 2 ** COUNT_W - 1;
                2: count = 0;
                3: count = 1;
                4: count = $urandom_range(8, 2);
                5: count = SEEDS + 1;
                6: count = $urandom_range(SEEDS, 1);
                7: count = SEEDS;
                default: count = $urandom_range(20, 9);
            endcase
            set_seed_count(count);
            // starve the result side while the sender keeps pushing
            if (phase == 0 || phase == 4)
                hold_requests <= hold_requests + 1;
            repeat (PHASE_ITEMS) random_item();
        end

        drain_results();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/nsvc_pkg.sv
rtl/nsvc_ram.sv
rtl/nsvc_dist.sv
rtl/nsvc_seq.sv
rtl/nearest_seed_voronoi_color.sv
tb/sv/nearest_seed_voronoi_color_checker.sv
tb/sv/nearest_seed_voronoi_color_tb.sv
